FILE: design/dlfb_pkg.sv
// Shared types and constants of the dense layer forward/backward core.
package dlfb_pkg;

  localparam int MAX_IN_DEF    = 64;
  localparam int MAX_OUT_DEF   = 64;
  localparam int MAX_BATCH_DEF = 16;

  localparam int DATA_W    = 16;
  localparam int ACC_W     = 40;
  localparam int SUM_W     = 41;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int KIND_W    = 3;
  localparam int RKIND_W   = 2;
  localparam int RES_LIMIT = 64;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [KIND_W-1:0] {
    K_LOAD_W  = 3'd0,
    K_LOAD_B  = 3'd1,
    K_ACT     = 3'd2,
    K_OGRAD   = 3'd3,
    K_READ_GW = 3'd4,
    K_READ_GB = 3'd5
  } in_kind_t;

  typedef enum logic [RKIND_W-1:0] {
    R_FWD   = 2'd0,
    R_IGRAD = 2'd1,
    R_WGRAD = 2'd2,
    R_BGRAD = 2'd3
  } res_kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_NIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS = 2'd2;

  typedef struct packed {
    logic                    valid;
    res_kind_t               kind;
    logic [IDX_W-1:0]        index;
    logic signed [SUM_W-1:0] acc;
    logic                    last;
  } emit_req_t;

endpackage

FILE: design/dlfb_emit.sv
// Result rounding, saturation and output word register.
module dlfb_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  dlfb_pkg::emit_req_t           req,
  output logic                          ready,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,  // index[5:0], value[21:6], saturated[22]
  output logic [dlfb_pkg::RKIND_W-1:0]  m_tuser,  // result_kind[1:0]
  output logic                          m_tlast
);
  import dlfb_pkg::*;

  logic signed [SUM_W:0]    t;
  logic signed [SUM_W:0]    q;
  logic signed [DATA_W-1:0] val;
  logic                     sat;

  always_comb begin
    t   = (SUM_W+1)'(req.acc) + 42'sd2048;
    q   = t >>> 12;
    sat = 1'b0;
    val = q[DATA_W-1:0];
    if (q > 42'sd32767) begin
      val = 16'sh7fff;
      sat = 1'b1;
    end else if (q < -42'sd32768) begin
      val = 16'sh8000;
      sat = 1'b1;
    end
  end

  assign ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ready) begin
      m_tvalid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && req.valid) begin
      m_tdata <= {1'b0, sat, val, req.index};
      m_tuser <= req.kind;
      m_tlast <= req.last;
    end
  end

endmodule

FILE: design/dense_layer_forward_backward_core.sv
// Dense layer forward/backward core: stores, sequencer and shared multiply-accumulate.
// Loads write their store while idle. A completed activation row yields nout sums of
// nin products, one MAC per cycle through the weight memory read port, then a drain
// and emit. A gradient element does the weight-gradient read-modify-write over nin;
// a completed gradient row adds nin sums of nout products; gradient reads emit one sum.
// Synchronous reset restores the registers to 64/64/bias on; stores are not cleared.
module dense_layer_forward_backward_core #(
  parameter int MAX_IN    = dlfb_pkg::MAX_IN_DEF,
  parameter int MAX_OUT   = dlfb_pkg::MAX_OUT_DEF,
  parameter int MAX_BATCH = dlfb_pkg::MAX_BATCH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [31:0]                    s_tdata,  // row[5:0], col[11:6], value[27:12]
  input  logic [dlfb_pkg::KIND_W-1:0]    s_tuser,  // kind[2:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [23:0]                    m_tdata,  // index[5:0], value[21:6], saturated[22]
  output logic [dlfb_pkg::RKIND_W-1:0]   m_tuser,  // result_kind[1:0]
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [dlfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dlfb_pkg::CNT_W-1:0]     cfg_data
);
  import dlfb_pkg::*;

  localparam int WDEPTH   = MAX_IN * MAX_OUT;
  localparam int ADEPTH   = MAX_BATCH * MAX_IN;
  localparam int WA_W     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int AA_W     = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;
  localparam int BA_W     = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int NIN_LIM  = (MAX_IN < RES_LIMIT) ? MAX_IN : RES_LIMIT;
  localparam int NOUT_LIM = (MAX_OUT < RES_LIMIT) ? MAX_OUT : RES_LIMIT;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_MAC    = 8'b00000010,
    S_DRAIN  = 8'b00000100,
    S_EMIT   = 8'b00001000,
    S_GRAD   = 8'b00010000,
    S_GDRAIN = 8'b00100000,
    S_RD     = 8'b01000000,
    S_RDW    = 8'b10000000
  } state_t;

  state_t state;

  logic [CNT_W-1:0] cfg_nin, cfg_nout;
  logic             cfg_bias;
  logic [CNT_W-1:0] nin, nout, nk, no;

  logic [IDX_W-1:0]         in_row, in_col;
  logic signed [DATA_W-1:0] in_val;
  logic                     acc_in;
  logic                     w_ok, b_ok, act_ok, gr_ok;

  logic [IDX_W-1:0]         it_row, it_col, o, k;
  logic signed [DATA_W-1:0] it_val;
  logic                     fwd, gmode, single, rd_ok;
  res_kind_t                ekind;
  logic signed [SUM_W-1:0]  acc;

  logic                     p1, p2;
  logic [WA_W-1:0]          p1_addr, p2_addr;
  logic signed [31:0]       prod;
  logic signed [ACC_W-1:0]  g_old;

  logic signed [DATA_W-1:0] w_mem [WDEPTH];
  logic signed [DATA_W-1:0] b_mem [MAX_OUT];
  logic signed [DATA_W-1:0] a_mem [ADEPTH];
  logic signed [DATA_W-1:0] g_mem [MAX_OUT];
  logic signed [ACC_W-1:0]  wg_mem [WDEPTH];
  logic signed [ACC_W-1:0]  bg_mem [MAX_OUT];

  logic signed [DATA_W-1:0] w_q, b_q, a_q, g_q, op_a, op_b;
  logic signed [ACC_W-1:0]  wg_q, bg_q, wg_wdata, bg_wdata;
  logic [WA_W-1:0]          w_raddr, wg_raddr;
  logic [AA_W-1:0]          a_raddr;
  logic                     w_we, b_we, a_we, g_we, wg_we, bg_we;
  logic signed [SUM_W-1:0]  wsum, bsum, vterm;
  logic                     pipe_empty;

  emit_req_t req;
  logic      em_ready;

  assign in_row = s_tdata[5:0];
  assign in_col = s_tdata[11:6];
  assign in_val = signed'(s_tdata[27:12]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_nin  <= CNT_W'(64);
      cfg_nout <= CNT_W'(64);
      cfg_bias <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NIN:  cfg_nin  <= cfg_data;
        CFG_NOUT: cfg_nout <= cfg_data;
        CFG_BIAS: cfg_bias <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_nin == '0) nin = CNT_W'(1);
    else if (cfg_nin > CNT_W'(NIN_LIM)) nin = CNT_W'(NIN_LIM);
    else nin = cfg_nin;
    if (cfg_nout == '0) nout = CNT_W'(1);
    else if (cfg_nout > CNT_W'(NOUT_LIM)) nout = CNT_W'(NOUT_LIM);
    else nout = cfg_nout;
  end

  assign nk = (fwd || gmode) ? nin : nout;
  assign no = fwd ? nout : nin;

  assign s_tready = (state == S_IDLE);
  assign acc_in   = s_tvalid && s_tready;
  assign w_ok     = (32'(in_row) < MAX_IN) && (32'(in_col) < MAX_OUT);
  assign b_ok     = 32'(in_col) < MAX_OUT;
  assign act_ok   = (32'(in_row) < MAX_BATCH) && ({1'b0, in_col} < nin);
  assign gr_ok    = (32'(in_row) < MAX_BATCH) && ({1'b0, in_col} < nout);

  assign w_we = acc_in && (s_tuser == K_LOAD_W) && w_ok;
  assign b_we = acc_in && (s_tuser == K_LOAD_B) && b_ok;
  assign a_we = acc_in && (s_tuser == K_ACT) && act_ok;
  assign g_we = acc_in && (s_tuser == K_OGRAD) && gr_ok;

  assign a_raddr  = AA_W'(32'(it_row) * MAX_IN + 32'(k));
  assign w_raddr  = fwd ? WA_W'(32'(k) * MAX_OUT + 32'(o)) : WA_W'(32'(o) * MAX_OUT + 32'(k));
  assign wg_raddr = (state == S_RD) ? WA_W'(32'(it_row) * MAX_OUT + 32'(it_col))
                                    : WA_W'(32'(k) * MAX_OUT + 32'(it_col));

  always_ff @(posedge clk) begin
    if (w_we) w_mem[WA_W'(32'(in_row) * MAX_OUT + 32'(in_col))] <= in_val;
    w_q <= w_mem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) b_mem[BA_W'(in_col)] <= in_val;
    b_q <= b_mem[BA_W'(o)];
  end

  always_ff @(posedge clk) begin
    if (a_we) a_mem[AA_W'(32'(in_row) * MAX_IN + 32'(in_col))] <= in_val;
    a_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (g_we) g_mem[BA_W'(in_col)] <= in_val;
    g_q <= g_mem[BA_W'(k)];
  end

  always_ff @(posedge clk) begin
    if (wg_we) wg_mem[p2_addr] <= wg_wdata;
    wg_q <= wg_mem[wg_raddr];
  end

  always_ff @(posedge clk) begin
    if (bg_we) bg_mem[BA_W'(it_col)] <= bg_wdata;
    bg_q <= bg_mem[BA_W'(it_col)];
  end

  assign op_a = (gmode || fwd) ? a_q : g_q;
  assign op_b = gmode ? it_val : w_q;

  assign pipe_empty = !p1 && !p2;
  assign vterm      = SUM_W'(it_val) <<< 12;
  assign wsum       = (it_row == '0) ? SUM_W'(prod) : SUM_W'(g_old) + SUM_W'(prod);
  assign bsum       = (it_row == '0) ? vterm : SUM_W'(bg_q) + vterm;

  always_comb begin
    if (wsum[SUM_W-1] != wsum[SUM_W-2]) wg_wdata = {wsum[SUM_W-1], {(ACC_W-1){!wsum[SUM_W-1]}}};
    else wg_wdata = wsum[ACC_W-1:0];
    if (bsum[SUM_W-1] != bsum[SUM_W-2]) bg_wdata = {bsum[SUM_W-1], {(ACC_W-1){!bsum[SUM_W-1]}}};
    else bg_wdata = bsum[ACC_W-1:0];
  end

  assign wg_we = p2 && gmode;
  assign bg_we = (state == S_GDRAIN) && pipe_empty && cfg_bias;

  // multiply stage, then accumulate or gradient write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= 1'b0;
      p2 <= 1'b0;
    end else begin
      p1 <= (state == S_MAC) || (state == S_GRAD);
      p2 <= p1;
    end
    p1_addr <= wg_raddr;
    p2_addr <= p1_addr;
    prod    <= op_a * op_b;
    g_old   <= wg_q;
  end

  always_comb begin
    req.valid = (state == S_EMIT);
    req.kind  = ekind;
    req.index = single ? it_col : o;
    req.last  = single || ({1'b0, o} == no - CNT_W'(1));
    req.acc   = acc;
    if (ekind == R_FWD && cfg_bias) req.acc = acc + (SUM_W'(b_q) <<< 12);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      gmode <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc_in) begin
            it_row <= in_row;
            it_col <= in_col;
            it_val <= in_val;
            o      <= '0;
            k      <= '0;
            acc    <= '0;
            single <= 1'b0;
            unique case (s_tuser)
              K_ACT: begin
                if (act_ok && ({1'b0, in_col} == nin - CNT_W'(1))) begin
                  fwd   <= 1'b1;
                  ekind <= R_FWD;
                  state <= S_MAC;
                end
              end
              K_OGRAD: begin
                if (gr_ok) begin
                  gmode <= 1'b1;
                  fwd   <= 1'b0;
                  state <= S_GRAD;
                end
              end
              K_READ_GW: begin
                single <= 1'b1;
                rd_ok  <= w_ok;
                ekind  <= R_WGRAD;
                state  <= S_RD;
              end
              K_READ_GB: begin
                single <= 1'b1;
                rd_ok  <= cfg_bias && b_ok;
                ekind  <= R_BGRAD;
                state  <= S_RD;
              end
              default: ;
            endcase
          end
        end
        S_MAC: begin
          if ({1'b0, k} == nk - CNT_W'(1)) state <= S_DRAIN;
          else k <= k + IDX_W'(1);
        end
        S_DRAIN: begin
          if (pipe_empty) state <= S_EMIT;
        end
        S_EMIT: begin
          if (em_ready) begin
            if (req.last) begin
              state <= S_IDLE;
            end else begin
              o     <= o + IDX_W'(1);
              k     <= '0;
              acc   <= '0;
              state <= S_MAC;
            end
          end
        end
        S_GRAD: begin
          if ({1'b0, k} == nin - CNT_W'(1)) state <= S_GDRAIN;
          else k <= k + IDX_W'(1);
        end
        S_GDRAIN: begin
          if (pipe_empty) begin
            gmode <= 1'b0;
            if ({1'b0, it_col} == nout - CNT_W'(1)) begin
              ekind <= R_IGRAD;
              o     <= '0;
              k     <= '0;
              acc   <= '0;
              state <= S_MAC;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          if (!rd_ok) acc <= '0;
          else if (ekind == R_WGRAD) acc <= SUM_W'(wg_q);
          else acc <= SUM_W'(bg_q);
          state <= S_EMIT;
        end
        default: state <= S_IDLE;
      endcase
      if (p2 && !gmode) acc <= acc + SUM_W'(prod);
    end
  end

  dlfb_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .ready    (em_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  a_emit_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> pipe_empty) else $error("emit with MAC pipeline busy");

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !p2) else $error("word accepted while pipeline busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC) |-> ({1'b0, k} < nk)) else $error("MAC index past feature count");

endmodule
